// File: rtl/fire_effect_flame_filter_unit_assert.svh
// Assertion macros shared by the flame filter modules.
`ifndef FIRE_EFFECT_FLAME_FILTER_UNIT_ASSERT_SVH
`define FIRE_EFFECT_FLAME_FILTER_UNIT_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define FFU_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define FFU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/ffu_pkg.sv
// Package: constants, types and helpers of the flame filter.
`timescale 1ns / 1ps
package ffu_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int MIN_SIZE   = 3;

  localparam int PIX_W     = 8;
  localparam int COL_W     = $clog2(MAX_WIDTH);
  localparam int ROW_W     = $clog2(MAX_HEIGHT);
  localparam int CFG_W     = 11;
  localparam int CFG_IDX_W = 2;

  // seven 8-bit terms
  localparam int SUM_W = PIX_W + 3;

  // floor(sum / 7) == (sum * 9363) >> 16 for every sum up to 7 * 255
  localparam int            DIV7_SHIFT  = 16;
  localparam int            DIV7_MULT_W = 14;
  localparam logic [13:0]   DIV7_MULT   = 14'd9363;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = FIFO_AW + 1;

  localparam logic [CFG_W-1:0] WIDTH_RESET  = 11'd640;
  localparam logic [CFG_W-1:0] HEIGHT_RESET = 11'd480;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_WIDTH  = 2'd0,
    CFG_FRAME_HEIGHT = 2'd1
  } cfg_reg_t;

  typedef logic [PIX_W-1:0] pixel_t;

  typedef struct packed {
    pixel_t           heat;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             last;
  } result_t;

  // up to two results per input pixel; second only with first
  typedef struct packed {
    logic    vld0;
    logic    vld1;
    result_t res0;
    result_t res1;
  } push_t;

  // line buffer write port shared by both row stores
  typedef struct packed {
    logic             en;
    logic [COL_W-1:0] addr;
    pixel_t           older;
    pixel_t           newer;
  } line_wr_t;

  function automatic logic [CFG_W-1:0] clamp_size(input logic [CFG_W-1:0] v,
                                                  input logic [CFG_W-1:0] hi);
    logic [CFG_W-1:0] r;
    if (v < CFG_W'(MIN_SIZE)) r = CFG_W'(MIN_SIZE);
    else if (v > hi)          r = hi;
    else                      r = v;
    return r;
  endfunction

endpackage

// File: rtl/ffu_line_ram.sv
// Line buffer RAM: one write port, one read port with registered data.
`timescale 1ns / 1ps
module ffu_line_ram import ffu_pkg::*; (
  input  logic             clk,
  input  logic             we,
  input  logic [COL_W-1:0] waddr,
  input  pixel_t           wdata,
  input  logic [COL_W-1:0] raddr,
  output pixel_t           rdata
);

  pixel_t mem [MAX_WIDTH];
  pixel_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/ffu_core.sv
// Filter core: position counters, pixel window, averaging and result build.
`timescale 1ns / 1ps
module ffu_core import ffu_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  input  logic                 accept,
  input  pixel_t               pix,
  input  pixel_t               older_rd,
  input  pixel_t               newer_rd,
  output logic [COL_W-1:0]     rd_addr,
  output line_wr_t             line_wr,
  output push_t                push
);

  `include "fire_effect_flame_filter_unit_assert.svh"

  logic [CFG_W-1:0] width_r, width_nxt;
  logic [CFG_W-1:0] height_r, height_nxt;
  logic [COL_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  pixel_t           nb1_r, nb2_r, cur1_r, cur2_r, old0_r;
  pixel_t           prev_r, prev_nxt;

  logic [CFG_W-1:0] w_cl, h_cl;
  logic [COL_W-1:0] w_m1, col_adv;
  logic [ROW_W-1:0] h_m1;
  logic             col_wrap, emit, edge_col;
  logic [SUM_W-1:0] sum;
  logic [SUM_W+DIV7_MULT_W-1:0] prod;
  pixel_t           quot, first_heat;

  assign w_cl = clamp_size(width_r, CFG_W'(MAX_WIDTH));
  assign h_cl = clamp_size(height_r, CFG_W'(MAX_HEIGHT));
  assign w_m1 = COL_W'(w_cl - CFG_W'(1));
  assign h_m1 = ROW_W'(h_cl - CFG_W'(1));

  assign col_wrap = (col_r == w_m1);
  assign col_adv  = col_wrap ? '0 : col_r + COL_W'(1);

  // read one column ahead so data is ready when the pixel arrives
  assign rd_addr = cfg_we ? '0 : (accept ? col_adv : col_r);

  assign line_wr.en    = accept;
  assign line_wr.addr  = col_r;
  assign line_wr.older = newer_rd;
  assign line_wr.newer = pix;

  assign sum = SUM_W'(prev_r) + SUM_W'(older_rd) + SUM_W'(nb2_r) + SUM_W'(newer_rd)
             + SUM_W'(cur2_r) + SUM_W'(cur1_r) + SUM_W'(pix);
  assign prod = (SUM_W+DIV7_MULT_W)'(sum) * (SUM_W+DIV7_MULT_W)'(DIV7_MULT);
  assign quot = prod[DIV7_SHIFT +: PIX_W];

  assign emit       = (row_r >= ROW_W'(2)) && (col_r != '0);
  assign edge_col   = (col_r == COL_W'(1));
  assign first_heat = edge_col ? old0_r : quot;

  always_comb begin
    push.vld0      = accept && emit;
    push.vld1      = accept && emit && col_wrap;
    push.res0.heat = first_heat;
    push.res0.row  = row_r - ROW_W'(2);
    push.res0.col  = col_r - COL_W'(1);
    push.res0.last = !col_wrap;
    push.res1.heat = older_rd;
    push.res1.row  = row_r - ROW_W'(2);
    push.res1.col  = col_r;
    push.res1.last = 1'b1;
  end

  always_comb begin
    width_nxt  = width_r;
    height_nxt = height_r;
    col_nxt    = col_r;
    row_nxt    = row_r;
    prev_nxt   = prev_r;
    if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        CFG_FRAME_WIDTH:  width_nxt  = cfg_wdata;
        CFG_FRAME_HEIGHT: height_nxt = cfg_wdata;
        default: ;
      endcase
      col_nxt = '0;
      row_nxt = '0;
    end else if (accept) begin
      col_nxt = col_adv;
      if (col_wrap) begin
        row_nxt = (row_r == h_m1) ? '0 : row_r + ROW_W'(1);
      end
      if (emit) begin
        prev_nxt = first_heat;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RESET;
      height_r <= HEIGHT_RESET;
      col_r    <= '0;
      row_r    <= '0;
      prev_r   <= '0;
      nb1_r    <= '0;
      nb2_r    <= '0;
      cur1_r   <= '0;
      cur2_r   <= '0;
      old0_r   <= '0;
    end else begin
      width_r  <= width_nxt;
      height_r <= height_nxt;
      col_r    <= col_nxt;
      row_r    <= row_nxt;
      prev_r   <= prev_nxt;
      if (accept) begin
        nb2_r  <= nb1_r;
        nb1_r  <= newer_rd;
        cur2_r <= cur1_r;
        cur1_r <= pix;
        if (col_r == '0) begin
          old0_r <= older_rd;
        end
      end
    end
  end

  `FFU_ASSERT_NOW(a_col_in_row, 1'b1, col_r <= w_m1, "column count beyond row width")
  `FFU_ASSERT_NEXT(a_cfg_restart, cfg_we, (col_r == '0) && (row_r == '0), "config did not restart frame")
  `FFU_ASSERT_NOW(a_rd_ahead, accept, rd_addr != col_r, "read collides with line write")

endmodule

// File: rtl/ffu_out_fifo.sv
// Result queue: takes up to two results a cycle, hands out one.
`timescale 1ns / 1ps
module ffu_out_fifo import ffu_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  push_t   push,
  output logic    full_soon,
  output logic    out_valid,
  input  logic    out_stall,
  output result_t head
);

  `include "fire_effect_flame_filter_unit_assert.svh"

  result_t            slot_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [FIFO_CW-1:0] cnt_r, cnt_nxt;
  logic               pop;
  logic [FIFO_AW-1:0] wp_p1;

  assign out_valid = (cnt_r != '0);
  assign pop       = out_valid && !out_stall;
  assign head      = slot_r[rp_r];
  // room for two more results must remain when an input is taken
  assign full_soon = (cnt_r > FIFO_CW'(FIFO_DEPTH - 2));
  assign wp_p1     = wp_r + FIFO_AW'(1);

  always_comb begin
    wp_nxt  = wp_r + FIFO_AW'(push.vld0) + FIFO_AW'(push.vld1);
    rp_nxt  = rp_r + FIFO_AW'(pop);
    cnt_nxt = cnt_r + FIFO_CW'(push.vld0) + FIFO_CW'(push.vld1) - FIFO_CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (push.vld0) begin
      slot_r[wp_r] <= push.res0;
    end
    if (push.vld1) begin
      slot_r[wp_p1] <= push.res1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  `FFU_ASSERT_NOW(a_no_overflow, 1'b1, cnt_r <= FIFO_CW'(FIFO_DEPTH), "result queue overflow")
  `FFU_ASSERT_NOW(a_pair_order, push.vld1, push.vld0, "second result without first")
  `FFU_ASSERT_NOW(a_push_room, push.vld0, !full_soon, "result pushed while queue nearly full")

endmodule

// File: rtl/fire_effect_flame_filter_unit.sv
// Top level of the fire effect flame filter.
`timescale 1ns / 1ps
// Flame filter for a fire effect. Old heat pixels enter in raster order on
// the in_ channel, one transaction per pixel, and updated pixels of rows 0
// to height-3 leave on the out_ channel tagged with row and column. Each
// interior pixel becomes the floor of the mean of seven neighbors (the
// freshly updated left pixel, the old right pixel, two pixels of the next
// row and three of the row after), edge columns pass through. Input (y,x)
// with y>=2 and x>=1 yields pixel (y-2,x-1); the last column of a row also
// yields (y-2,width-1), and out_last_of_run marks the final result of an
// input. Sustained rate is one pixel per clock while in_stall is low: each
// pixel does a single read-modify-write of the two 1024-entry line buffers
// (read issued one column ahead, so the data is registered by the time the
// pixel arrives) and the divide-by-seven feedback closes in that same cycle.
// Results pass through a four-entry queue; in_stall rises while three or
// more results wait. Writing either size register restarts the frame, so
// the first two rows only refill the line buffers; write registers only
// while idle. Sizes below 3 act as 3, sizes above 1024 act as 1024.
module fire_effect_flame_filter_unit import ffu_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [PIX_W-1:0]     in_heat_in,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [PIX_W-1:0]     out_heat_out,
  output logic [ROW_W-1:0]     out_row,
  output logic [COL_W-1:0]     out_col,
  output logic                 out_last_of_run
);

  logic             accept;
  logic [COL_W-1:0] rd_addr;
  line_wr_t         line_wr;
  pixel_t           older_rd, newer_rd;
  push_t            push;
  result_t          head;
  logic             full_soon;

  assign in_stall = full_soon;
  assign accept   = in_valid && !in_stall;

  // row y-2 store
  ffu_line_ram u_older_ram (
    .clk   (clk),
    .we    (line_wr.en),
    .waddr (line_wr.addr),
    .wdata (line_wr.older),
    .raddr (rd_addr),
    .rdata (older_rd)
  );

  // row y-1 store
  ffu_line_ram u_newer_ram (
    .clk   (clk),
    .we    (line_wr.en),
    .waddr (line_wr.addr),
    .wdata (line_wr.newer),
    .raddr (rd_addr),
    .rdata (newer_rd)
  );

  ffu_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .accept    (accept),
    .pix       (in_heat_in),
    .older_rd  (older_rd),
    .newer_rd  (newer_rd),
    .rd_addr   (rd_addr),
    .line_wr   (line_wr),
    .push      (push)
  );

  ffu_out_fifo u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .full_soon (full_soon),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .head      (head)
  );

  assign out_heat_out    = head.heat;
  assign out_row         = head.row;
  assign out_col         = head.col;
  assign out_last_of_run = head.last;

endmodule

// File: bench/fire_effect_flame_filter_unit_test.sv
// Self-checking testbench for the fire effect flame filter unit.
`timescale 1ns / 1ps
// Drives old heat pixels in raster order, predicts every updated pixel with a
// local copy of the filter state (two line stores, tap registers, left value,
// raster position) and checks each output transaction, field by field, against
// the oldest predicted result. Tests run in turn from one initial block:
// reset sizes, heat extremes on the smallest frame, size clamping at both ends,
// restart on a write to an unmapped register, a long output hold-off, and
// random frames with random sizes and mid-frame restarts.
module fire_effect_flame_filter_unit_test;
  import ffu_pkg::*;

  localparam int CLK_HALF      = 2;
  localparam int RESET_CYCLES  = 7;
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int SETTLE_CYCLES = 16;   // line buffer read, filter stage, result queue
  localparam int HOLD_CYCLES   = 300;
  localparam int RANDOM_PIXELS = 360;
  localparam int HEAT_TAPS     = 7;    // terms in the flame average
  localparam int PIX_MAX       = 255;

  // no register lives here; a write still restarts the frame
  localparam logic [CFG_IDX_W-1:0] UNUSED_CFG_INDEX = 2'd3;

  typedef enum int unsigned {
    HEAT_ANY,    // full range
    HEAT_RAILS,  // 0 or 255 only
    HEAT_DIM,    // low embers
    HEAT_HOT     // near saturation
  } heat_style_t;

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_wdata = '0;
  logic                 in_valid  = 1'b0;
  logic                 in_stall;
  logic [PIX_W-1:0]     in_heat_in = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [PIX_W-1:0]     out_heat_out;
  logic [ROW_W-1:0]     out_row;
  logic [COL_W-1:0]     out_col;
  logic                 out_last_of_run;

  fire_effect_flame_filter_unit u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_heat_in      (in_heat_in),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_heat_out    (out_heat_out),
    .out_row         (out_row),
    .out_col         (out_col),
    .out_last_of_run (out_last_of_run)
  );

  always begin
    #(CLK_HALF) clk = 1'b1;
    #(CLK_HALF) clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Filter state as the block should hold it
  // ---------------------------------------------------------------------------
  logic [CFG_W-1:0] cur_width  = WIDTH_RESET;
  logic [CFG_W-1:0] cur_height = HEIGHT_RESET;
  pixel_t           line_two_up [MAX_WIDTH] = '{default: '0};  // old row y-2
  pixel_t           line_one_up [MAX_WIDTH] = '{default: '0};  // old row y-1
  pixel_t           above_x1      = '0;  // row y-1 at x-1
  pixel_t           above_x2      = '0;  // row y-1 at x-2
  pixel_t           cur_x1        = '0;  // row y at x-1
  pixel_t           cur_x2        = '0;  // row y at x-2
  pixel_t           row_start_old = '0;  // row y-2 at column 0
  pixel_t           last_heat     = '0;  // updated pixel to the left
  int unsigned      col_pos = 0;
  int unsigned      row_pos = 0;

  result_t     expected_results [$];
  int unsigned mismatches      = 0;
  int unsigned results_checked = 0;
  int unsigned pixels_sent     = 0;
  int unsigned cfg_writes      = 0;

  // pacing shared by both sides; hold requests are counted by the receiver
  bit          idle_on      = 1'b1;
  int unsigned hold_trigger = 0;
  int unsigned hold_seen    = 0;
  int unsigned hold_left    = 0;
  int unsigned gap_left     = 0;
  int unsigned cycle_count  = 0;

  function automatic int unsigned effective_size(input logic [CFG_W-1:0] value,
                                                 input int unsigned ceiling);
    if (value < MIN_SIZE) return MIN_SIZE;
    if (value > ceiling) return ceiling;
    return 32'(value);
  endfunction

  function automatic pixel_t draw_heat(input heat_style_t style);
    case (style)
      HEAT_RAILS: return $urandom_range(0, 1) ? pixel_t'(PIX_MAX) : pixel_t'(0);
      HEAT_DIM:   return pixel_t'($urandom_range(0, 15));
      HEAT_HOT:   return pixel_t'($urandom_range(PIX_MAX - 15, PIX_MAX));
      default:    return pixel_t'($urandom_range(0, PIX_MAX));
    endcase
  endfunction

  task automatic add_expected(input pixel_t heat, input int unsigned row,
                              input int unsigned col, input logic last);
    result_t res;
    res.heat = heat;
    res.row  = ROW_W'(row);
    res.col  = COL_W'(col);
    res.last = last;
    expected_results.push_back(res);
  endtask

  // One accepted pixel: emit the updated pixels it completes, then shift it in.
  task automatic filter_pixel(input pixel_t heat);
    int unsigned span, depth, x, y, total;
    pixel_t      two_up, one_up;
    span  = effective_size(cur_width, MAX_WIDTH);
    depth = effective_size(cur_height, MAX_HEIGHT);
    if (col_pos >= span) col_pos = 0;
    if (row_pos >= depth) row_pos = 0;
    x = col_pos;
    y = row_pos;
    two_up = line_two_up[x];
    one_up = line_one_up[x];

    // rows 0 and 1 and column 0 only fill the stores
    if (y >= 2 && x >= 1) begin
      if (x == 1) begin
        // left edge passes through
        last_heat = row_start_old;
        add_expected(last_heat, y - 2, 0, span - 1 != 1);
      end else begin
        total = 0;
        total += last_heat;
        total += two_up;
        total += above_x2;
        total += one_up;
        total += cur_x2;
        total += cur_x1;
        total += heat;
        last_heat = pixel_t'(total / HEAT_TAPS);
        add_expected(last_heat, y - 2, x - 1, x != span - 1);
      end
      // right edge passes through on the same input
      if (x == span - 1) add_expected(two_up, y - 2, x, 1'b1);
    end

    above_x2 = above_x1;
    above_x1 = one_up;
    cur_x2   = cur_x1;
    cur_x1   = heat;
    if (x == 0) row_start_old = two_up;
    line_two_up[x] = one_up;
    line_one_up[x] = heat;

    col_pos = x + 1;
    if (col_pos >= span) begin
      col_pos = 0;
      row_pos = y + 1;
      if (row_pos >= depth) row_pos = 0;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------------
  // Valid is left high after acceptance; the next call lowers it only before an
  // idle gap, and a register write lowers it too, so it never drops and rises within one step.
  task automatic send_heat(input pixel_t heat);
    int unsigned gap;
    gap = idle_on ? $urandom_range(0, 9) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_heat_in <= heat;
    do begin
      @(posedge clk);
    end while (in_stall);
    filter_pixel(heat);
    pixels_sent++;
  endtask

  task automatic wait_for_drain();
    while (expected_results.size() != 0) @(posedge clk);
    // pixels of rows 0/1 leave no result but may still be in flight
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Any write restarts the frame, also one to an unmapped index.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input logic [CFG_W-1:0] value);
    in_valid <= 1'b0;
    wait_for_drain();
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (index)
      CFG_FRAME_WIDTH:  cur_width  = value;
      CFG_FRAME_HEIGHT: cur_height = value;
      default: ;
    endcase
    col_pos = 0;
    row_pos = 0;
    cfg_writes++;
  endtask

  // ---------------------------------------------------------------------------
  // Output side: pacing and checking
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : rx_pacing
    int unsigned wait_cycles;
    if (!rst_n) begin
      out_stall <= 1'b0;
      gap_left  <= 0;
      hold_left <= 0;
    end else if (hold_trigger != hold_seen) begin
      hold_seen <= hold_trigger;
      hold_left <= HOLD_CYCLES - 1;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (out_valid && !out_stall) begin
      wait_cycles = idle_on ? $urandom_range(0, 9) : 0;
      gap_left  <= wait_cycles;
      out_stall <= (wait_cycles != 0);
    end else if (gap_left > 1) begin
      gap_left  <= gap_left - 1;
      out_stall <= 1'b1;
    end else begin
      gap_left  <= 0;
      out_stall <= 1'b0;
    end
  end

  task automatic check_field(input string what, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : result_check
    result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual heat %0d row %0d col %0d",
                 $time, out_heat_out, out_row, out_col);
        mismatches++;
      end else begin
        want = expected_results.pop_front();
        check_field("heat_out", 16'(want.heat), 16'(out_heat_out));
        check_field("out_row", 16'(want.row), 16'(out_row));
        check_field("out_col", 16'(want.col), 16'(out_col));
        check_field("last_of_run", 16'(want.last), 16'(out_last_of_run));
        results_checked++;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d results outstanding",
               $time, cycle_count, expected_results.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // Reset sizes 640x480: a stretch of row 0 only fills the stores and must
  // leave nothing on the output.
  task automatic test_reset_sizes();
    repeat (64) send_heat(draw_heat(HEAT_ANY));
  endtask

  // Smallest frame, saturated and alternating heat.
  task automatic test_heat_extremes();
    write_reg(CFG_FRAME_WIDTH, CFG_W'(MIN_SIZE));
    write_reg(CFG_FRAME_HEIGHT, CFG_W'(MIN_SIZE));
    repeat (9) send_heat(pixel_t'(PIX_MAX));
    for (int i = 0; i < 9; i++) send_heat((i % 2 == 0) ? pixel_t'(PIX_MAX) : pixel_t'(0));
  endtask

  // Sizes below the floor act as 3.
  task automatic test_size_floor();
    write_reg(CFG_FRAME_WIDTH, '0);
    write_reg(CFG_FRAME_HEIGHT, CFG_W'(1));
    repeat (12) send_heat(draw_heat(HEAT_ANY));
    write_reg(CFG_FRAME_WIDTH, CFG_W'(2));
    write_reg(CFG_FRAME_HEIGHT, CFG_W'(2));
    repeat (9) send_heat(draw_heat(HEAT_RAILS));
  endtask

  // Sizes above the ceiling: a stretch of a maximal-width row that only fills
  // the stores, then narrow rows of a maximal-height frame that do emit.
  task automatic test_size_ceiling();
    write_reg(CFG_FRAME_WIDTH, '1);
    write_reg(CFG_FRAME_HEIGHT, CFG_W'(MIN_SIZE));
    repeat (48) send_heat(draw_heat(HEAT_ANY));
    write_reg(CFG_FRAME_WIDTH, CFG_W'(MIN_SIZE));
    write_reg(CFG_FRAME_HEIGHT, '1);
    repeat (3 * 16) send_heat(draw_heat(HEAT_ANY));
  endtask

  // Write to an unmapped index mid-frame: sizes stay, frame restarts.
  task automatic test_unused_index();
    write_reg(CFG_FRAME_WIDTH, CFG_W'(4));
    write_reg(CFG_FRAME_HEIGHT, CFG_W'(4));
    repeat (14) send_heat(draw_heat(HEAT_ANY));
    write_reg(UNUSED_CFG_INDEX, CFG_W'($urandom_range(0, 2047)));
    repeat (16) send_heat(draw_heat(HEAT_ANY));
  endtask

  // Receiver holds off for a long stretch while pixels keep coming, so the
  // result queue fills and the input stalls.
  task automatic test_backpressure();
    write_reg(CFG_FRAME_WIDTH, CFG_W'(5));
    write_reg(CFG_FRAME_HEIGHT, CFG_W'(6));
    idle_on      <= 1'b0;
    hold_trigger <= hold_trigger + 1;
    repeat (60) send_heat(draw_heat(HEAT_ANY));
    idle_on <= 1'b1;
  endtask

  // Random sizes, mostly small; pixel runs of whole rows plus a ragged tail,
  // so frames wrap and get cut off by the next size change.
  task automatic test_random_frames();
    int unsigned done, count, span, pick, w, h;
    heat_style_t style;
    done = 0;
    while (done < RANDOM_PIXELS) begin
      idle_on <= ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 3) != 0) begin
        pick = $urandom_range(0, 9);
        if (pick == 0)      w = $urandom_range(0, 2);
        else if (pick == 1) w = $urandom_range(13, 40);
        else                w = $urandom_range(3, 12);
        h = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 6);
        if ($urandom_range(0, 1)) begin
          write_reg(CFG_FRAME_WIDTH, CFG_W'(w));
          write_reg(CFG_FRAME_HEIGHT, CFG_W'(h));
        end else begin
          write_reg(CFG_FRAME_HEIGHT, CFG_W'(h));
          write_reg(CFG_FRAME_WIDTH, CFG_W'(w));
        end
      end
      span  = effective_size(cur_width, MAX_WIDTH);
      count = span * $urandom_range(1, 8) + $urandom_range(0, span - 1);
      style = heat_style_t'($urandom_range(0, 3));
      repeat (count) send_heat(draw_heat(style));
      done += count;
    end
    idle_on <= 1'b1;
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_sizes();
    test_heat_extremes();
    test_size_floor();
    test_size_ceiling();
    test_unused_index();
    test_backpressure();
    test_random_frames();

    in_valid <= 1'b0;
    wait_for_drain();

    $display("Sent %0d heat pixels, checked %0d filtered pixels, %0d register writes.",
             pixels_sent, results_checked, cfg_writes);
    $display("Frames ran from the 3x3 floor to sizes written past the ceiling, with a long output hold-off.");
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
